>>> sv/pps_pkg.sv
`default_nettype none
package pps_pkg;

    localparam int DEF_NUM_SLOTS = 16;

    localparam int SLOT_IN_W = 4;
    localparam int ARR_W     = 16;
    localparam int BURST_W   = 16;
    localparam int PRIO_W    = 8;
    localparam int TIME_W    = 24;
    localparam int SUM_W     = 28;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] remaining;
    } entry_t;

    typedef struct packed {
        logic                 ran_valid;
        logic [SLOT_IN_W-1:0] ran_slot;
        logic                 finished;
        logic [TIME_W-1:0]    completion_time;
        logic [TIME_W-1:0]    turnaround_time;
        logic [TIME_W-1:0]    waiting_time;
        logic [SUM_W-1:0]     total_turnaround;
        logic [SUM_W-1:0]     total_waiting;
        logic                 all_done;
        logic [TIME_W-1:0]    time_now;
    } res_t;

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> sv/pps_table.sv
`default_nettype none
module pps_table #(
    parameter int NUM_SLOTS = pps_pkg::DEF_NUM_SLOTS
) (
    input  wire logic                         aclk,
    input  wire logic                         we,
    input  wire logic [$clog2(NUM_SLOTS)-1:0] waddr,
    input  wire pps_pkg::entry_t              wdata,
    input  wire logic                         re,
    input  wire logic [$clog2(NUM_SLOTS)-1:0] raddr,
    output pps_pkg::entry_t                   rdata
);
    import pps_pkg::*;

    entry_t mem [NUM_SLOTS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/pps_core.sv
`default_nettype none
module pps_core #(
    parameter int NUM_SLOTS = pps_pkg::DEF_NUM_SLOTS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         in_func,
    input  wire logic [pps_pkg::SLOT_IN_W-1:0] in_slot,
    input  wire logic [pps_pkg::ARR_W-1:0]    in_arrival,
    input  wire logic [pps_pkg::BURST_W-1:0]  in_burst,
    input  wire logic [pps_pkg::PRIO_W-1:0]   in_prio,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output pps_pkg::res_t                     res,
    output logic                              mem_we,
    output logic [$clog2(NUM_SLOTS)-1:0]      mem_waddr,
    output pps_pkg::entry_t                   mem_wdata,
    output logic                              mem_re,
    output logic [$clog2(NUM_SLOTS)-1:0]      mem_raddr,
    input  wire pps_pkg::entry_t              mem_rdata
);
    import pps_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int IDX_W  = SLOT_W + 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W  = (IDX_W > SLOT_IN_W ? IDX_W : SLOT_IN_W) + 1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_RUN  = 7'b0000100,
        ST_TAT  = 7'b0001000,
        ST_SUM  = 7'b0010000,
        ST_WSUM = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   found_reg, found_next;
    logic [SLOT_W-1:0]      best_reg, best_next;
    entry_t                 best_ent_reg, best_ent_next;
    logic [TIME_W-1:0]      time_reg, time_next;
    logic [SUM_W-1:0]       sum_tat_reg, sum_tat_next;
    logic [SUM_W-1:0]       sum_wt_reg, sum_wt_next;
    logic [NUM_SLOTS-1:0]   loaded_reg, loaded_next;
    logic [NUM_SLOTS-1:0]   done_reg, done_next;
    logic [CNT_W-1:0]       loaded_cnt_reg, loaded_cnt_next;
    logic [CNT_W-1:0]       done_cnt_reg, done_cnt_next;
    logic                   ran_valid_reg, ran_valid_next;
    logic                   finished_reg, finished_next;
    logic [SLOT_IN_W-1:0]   ran_slot_reg, ran_slot_next;
    logic [TIME_W-1:0]      comp_reg, comp_next;
    logic [TIME_W-1:0]      tat_reg, tat_next;
    logic [TIME_W-1:0]      wt_reg, wt_next;

    logic [TIME_W-1:0]      time_inc;
    logic [SLOT_W-1:0]      cur_idx;
    logic [SLOT_W-1:0]      load_addr;
    logic                   slot_ok;
    logic                   cand;
    logic                   accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign time_inc  = (time_reg == TIME_MAX) ? time_reg : time_reg + TIME_W'(1);
    assign cur_idx   = SLOT_W'(scan_idx_reg - IDX_W'(1));
    assign load_addr = SLOT_W'(in_slot);
    assign slot_ok   = CMP_W'(in_slot) < CMP_W'(NUM_SLOTS);

    // candidate check on the entry read in the previous cycle
    assign cand = loaded_reg[cur_idx] && (mem_rdata.remaining != '0) &&
                  (TIME_W'(mem_rdata.arrival) <= time_reg) &&
                  (!found_reg || (mem_rdata.prio < best_ent_reg.prio));

    always_comb begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_ent_next   = best_ent_reg;
        time_next       = time_reg;
        sum_tat_next    = sum_tat_reg;
        sum_wt_next     = sum_wt_reg;
        loaded_next     = loaded_reg;
        done_next       = done_reg;
        loaded_cnt_next = loaded_cnt_reg;
        done_cnt_next   = done_cnt_reg;
        ran_valid_next  = ran_valid_reg;
        finished_next   = finished_reg;
        ran_slot_next   = ran_slot_reg;
        comp_next       = comp_reg;
        tat_next        = tat_reg;
        wt_next         = wt_reg;
        mem_we          = 1'b0;
        mem_waddr       = load_addr;
        mem_wdata       = '{arrival: in_arrival, burst: in_burst, prio: in_prio,
                            remaining: in_burst};
        mem_re          = 1'b0;
        mem_raddr       = '0;
        res_valid       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ran_valid_next = 1'b0;
                    finished_next  = 1'b0;
                    ran_slot_next  = '0;
                    comp_next      = '0;
                    tat_next       = '0;
                    wt_next        = '0;
                    if (in_func == FUNC_LOAD) begin
                        if (slot_ok) begin
                            mem_we = 1'b1;
                            loaded_next[load_addr] = 1'b1;
                            if (!loaded_reg[load_addr]) begin
                                loaded_cnt_next = loaded_cnt_reg + CNT_W'(1);
                            end
                            if (done_reg[load_addr]) begin
                                done_next[load_addr] = 1'b0;
                                done_cnt_next = done_cnt_reg - CNT_W'(1);
                            end
                        end
                        state_next = ST_OUT;
                    end else begin
                        mem_re        = 1'b1;
                        mem_raddr     = '0;
                        scan_idx_next = IDX_W'(1);
                        found_next    = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg != IDX_W'(NUM_SLOTS)) begin
                    mem_re    = 1'b1;
                    mem_raddr = scan_idx_reg[SLOT_W-1:0];
                end
                if (cand) begin
                    found_next    = 1'b1;
                    best_next     = cur_idx;
                    best_ent_next = mem_rdata;
                end
                if (scan_idx_reg == IDX_W'(NUM_SLOTS)) begin
                    state_next = ST_RUN;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_RUN: begin
                time_next  = time_inc;
                state_next = ST_OUT;
                if (found_reg) begin
                    ran_valid_next = 1'b1;
                    ran_slot_next  = SLOT_IN_W'(best_reg);
                    mem_we         = 1'b1;
                    mem_waddr      = best_reg;
                    mem_wdata      = best_ent_reg;
                    mem_wdata.remaining = best_ent_reg.remaining - BURST_W'(1);
                    if (best_ent_reg.remaining == BURST_W'(1)) begin
                        finished_next = 1'b1;
                        comp_next     = time_inc;
                        state_next    = ST_TAT;
                    end
                end
            end
            ST_TAT: begin
                tat_next   = comp_reg - TIME_W'(best_ent_reg.arrival);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                wt_next = (tat_reg >= TIME_W'(best_ent_reg.burst)) ?
                          tat_reg - TIME_W'(best_ent_reg.burst) : '0;
                sum_tat_next = sat_sum(sum_tat_reg, tat_reg);
                state_next   = ST_WSUM;
            end
            ST_WSUM: begin
                sum_wt_next = sat_sum(sum_wt_reg, wt_reg);
                if (!done_reg[best_reg]) begin
                    done_next[best_reg] = 1'b1;
                    done_cnt_next = done_cnt_reg + CNT_W'(1);
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.ran_valid        = ran_valid_reg;
        res.ran_slot         = ran_slot_reg;
        res.finished         = finished_reg;
        res.completion_time  = comp_reg;
        res.turnaround_time  = tat_reg;
        res.waiting_time     = wt_reg;
        res.total_turnaround = sum_tat_reg;
        res.total_waiting    = sum_wt_reg;
        res.all_done         = (done_cnt_reg == loaded_cnt_reg);
        res.time_now         = time_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            found_reg      <= 1'b0;
            time_reg       <= '0;
            sum_tat_reg    <= '0;
            sum_wt_reg     <= '0;
            loaded_reg     <= '0;
            done_reg       <= '0;
            loaded_cnt_reg <= '0;
            done_cnt_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            found_reg      <= found_next;
            time_reg       <= time_next;
            sum_tat_reg    <= sum_tat_next;
            sum_wt_reg     <= sum_wt_next;
            loaded_reg     <= loaded_next;
            done_reg       <= done_next;
            loaded_cnt_reg <= loaded_cnt_next;
            done_cnt_reg   <= done_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg  <= scan_idx_next;
        best_reg      <= best_next;
        best_ent_reg  <= best_ent_next;
        ran_valid_reg <= ran_valid_next;
        finished_reg  <= finished_next;
        ran_slot_reg  <= ran_slot_next;
        comp_reg      <= comp_next;
        tat_reg       <= tat_next;
        wt_reg        <= wt_next;
    end

endmodule
`default_nettype wire

>>> sv/preemptive_priority_scheduler.sv
// Preemptive priority scheduler over a table of NUM_SLOTS processes held in a
// single-port-read synchronous RAM. A load item (tuser 0) writes one entry and
// goes straight to its result. A tick item (tuser 1) reads the table one slot
// per cycle to find the arrived, unfinished entry with the lowest priority
// value (ties to the lowest slot), runs it for one unit and advances time;
// when the chosen process finishes, its turnaround and waiting times are
// computed and added to the running totals. One item is in work at a time;
// a finished result sits in the output register, so the next item is taken
// while it waits. Table contents are not cleared at reset; a per-slot loaded
// flag masks unloaded entries, so no clearing pass is needed.
`default_nettype none
module preemptive_priority_scheduler #(
    parameter int NUM_SLOTS = pps_pkg::DEF_NUM_SLOTS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // slot[3:0], arrival_in[19:4], burst_in[35:20], priority_in[43:36]
    input  wire logic [47:0]  s_tdata,
    // func[0]
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // ran_slot[3:0], finished[4], completion_time[28:5], turnaround_time[52:29],
    // waiting_time[76:53], total_turnaround[104:77], total_waiting[132:105],
    // all_done[133], time_now[157:134]
    output logic [159:0]      m_tdata,
    // ran_valid[0]
    output logic [0:0]        m_tuser
);
    import pps_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_raddr;
    entry_t            mem_rdata;

    logic              m_valid_reg, m_valid_next;
    res_t              m_res_reg;

    pps_core #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser[0]),
        .in_slot    (s_tdata[3:0]),
        .in_arrival (s_tdata[19:4]),
        .in_burst   (s_tdata[35:20]),
        .in_prio    (s_tdata[43:36]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    pps_table #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tuser[0] = m_res_reg.ran_valid;
    assign m_tdata    = {2'b00,
                         m_res_reg.time_now,
                         m_res_reg.all_done,
                         m_res_reg.total_waiting,
                         m_res_reg.total_turnaround,
                         m_res_reg.waiting_time,
                         m_res_reg.turnaround_time,
                         m_res_reg.completion_time,
                         m_res_reg.finished,
                         m_res_reg.ran_slot};

endmodule
`default_nettype wire
